// ===== rtl/scr_pkg.sv =====
// Shared types and constants of the sound control register device.
// Used by every module of the block; depends on nothing.

package scr_pkg;

    // number of stored sound register offsets
    localparam int SOUND_REG_COUNT = 36;

    // widths
    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 8;
    localparam int PHASE_W = 24;
    localparam int SMP_W   = 14;
    localparam int BANK_W  = 6;
    localparam int CH_W    = 3;
    localparam int OFS_W   = 9;

    // bus address decoding
    localparam logic [ADDR_W-1:0] CTRL_MASK = 16'hff80;
    localparam logic [ADDR_W-1:0] CTRL_BASE = 16'h9000;
    localparam logic [2:0]        FLIP_SEL  = 3'd7;
    localparam logic [ADDR_W-1:0] SND_FIRST = 16'h9828;
    localparam logic [ADDR_W-1:0] SND_LAST  = 16'h993f;
    localparam logic [ADDR_W-1:0] BANK_ADDR = 16'h9200;
    localparam logic [ADDR_W-1:0] WDOG_ADDR = 16'h9380;

    // sound register offsets
    localparam logic [OFS_W-1:0] OFS_CH4       = 9'h004;
    localparam logic [OFS_W-1:0] OFS_LOOP_LO   = 9'h008;
    localparam logic [OFS_W-1:0] OFS_LOOP_HI   = 9'h00b;
    localparam logic [OFS_W-1:0] OFS_CH_LO     = 9'h00c;
    localparam logic [OFS_W-1:0] OFS_CH_HI     = 9'h00f;
    localparam logic [OFS_W-1:0] OFS_STEP      = 9'h010;
    localparam logic [OFS_W-1:0] OFS_VOL       = 9'h011;
    localparam logic [OFS_W-1:0] OFS_LIMIT     = OFS_W'(SOUND_REG_COUNT);

    // channel 4 runs while its byte holds this code
    localparam logic [DATA_W-1:0] CH4_RUN_CODE = 8'hef;
    localparam logic [CH_W-1:0]   CH4_NUM      = 3'd4;

    // tone unit reset value
    localparam logic [PHASE_W-1:0] TONE_UNIT_RST = 24'd97391;

    // item kinds
    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_TICK  = 1'b1
    } func_t;

    // sample channel events
    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_START = 2'd1,
        EV_STOP  = 2'd2
    } chan_ev_t;

    // one input word
    typedef struct packed {
        logic              func;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
    } item_t;

    // one result word
    typedef struct packed {
        logic [SMP_W-1:0]  sample_out;
        logic [DATA_W-1:0] flip;
        logic [BANK_W-1:0] palette_bank;
        logic              watchdog_kick;
        chan_ev_t          channel_event;
        logic [CH_W-1:0]   channel;
        logic              channel_loop;
    } result_t;

endpackage

// ===== rtl/scr_in_stage.sv =====
// Input register of the sound control register device.
// Depends on scr_pkg for the input word type.

module scr_in_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  scr_pkg::item_t in_item,
    input  logic           advance,
    output logic           item_valid,
    output scr_pkg::item_t item
);

    logic           valid_reg;
    logic           valid_next;
    scr_pkg::item_t item_reg;
    logic           accept;

    // hold off the sender only while a held word cannot move on
    assign in_stall = valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    // control flop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload flop
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/scr_core.sv =====
// Write decoder, sound state and tone generator of the device.
// Depends on scr_pkg for types, address map and widths.

module scr_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [scr_pkg::PHASE_W-1:0]    cfg_data,
    input  logic                           advance,
    input  scr_pkg::item_t                 item,
    output scr_pkg::result_t               result
);

    // state
    logic [scr_pkg::PHASE_W-1:0] tone_unit_reg;
    logic [scr_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [scr_pkg::PHASE_W-1:0] step_reg, step_next;
    logic [scr_pkg::DATA_W-1:0]  volume_reg, volume_next;
    logic [scr_pkg::DATA_W-1:0]  flip_reg, flip_next;
    logic [scr_pkg::BANK_W-1:0]  bank_reg, bank_next;
    logic                        ch4_run_reg, ch4_run_next;
    logic [3:0]                  ch_bit_reg, ch_bit_next;
    logic [3:0]                  loop_zero_reg, loop_zero_next;

    // decode
    logic [scr_pkg::ADDR_W-1:0]  addr_diff;
    logic [scr_pkg::OFS_W-1:0]   offset;
    logic                        in_ctrl;
    logic                        in_snd;
    logic                        snd_ok;
    logic [1:0]                  sub;
    logic                        new_bit;
    logic                        old_bit;
    logic                        new_ch4;

    // tone step product
    logic [31:0]                 prod;
    logic [34:0]                 prod5;

    assign addr_diff = item.address - scr_pkg::SND_FIRST;
    assign offset    = addr_diff[scr_pkg::OFS_W-1:0];
    assign in_ctrl   = (item.address & scr_pkg::CTRL_MASK) == scr_pkg::CTRL_BASE;
    assign in_snd    = (item.address >= scr_pkg::SND_FIRST)
                    && (item.address <= scr_pkg::SND_LAST);
    assign snd_ok    = in_snd && (offset < scr_pkg::OFS_LIMIT);
    assign sub       = offset[1:0];
    assign new_bit   = item.data[0];
    assign old_bit   = ch_bit_reg[sub];
    assign new_ch4   = (item.data == scr_pkg::CH4_RUN_CODE);

    // step = unit * data * 5 / 256, kept to 24 bits
    assign prod  = 32'(tone_unit_reg) * 32'(item.data);
    assign prod5 = {1'b0, prod, 2'b00} + {3'b000, prod};

    // next state and result of the held word
    always_comb
    begin
        phase_next     = phase_reg;
        step_next      = step_reg;
        volume_next    = volume_reg;
        flip_next      = flip_reg;
        bank_next      = bank_reg;
        ch4_run_next   = ch4_run_reg;
        ch_bit_next    = ch_bit_reg;
        loop_zero_next = loop_zero_reg;

        result               = '0;
        result.channel_event = scr_pkg::EV_NONE;

        if (item.func == scr_pkg::FUNC_TICK)
        begin
            // tone sample, phase moves only while the step is nonzero
            if (step_reg != '0)
            begin
                if (phase_reg[scr_pkg::PHASE_W-1])
                begin
                    result.sample_out = {volume_reg, 6'b000000};
                end
                phase_next = phase_reg + step_reg;
            end
        end
        else if (in_ctrl)
        begin
            if (item.address[6:4] == scr_pkg::FLIP_SEL)
            begin
                flip_next = item.data;
            end
        end
        else if (in_snd)
        begin
            if (snd_ok)
            begin
                // channel 4 start and stop on its run code
                if (offset == scr_pkg::OFS_CH4)
                begin
                    if (new_ch4 && !ch4_run_reg)
                    begin
                        result.channel_event = scr_pkg::EV_START;
                        result.channel       = scr_pkg::CH4_NUM;
                        result.channel_loop  = 1'b1;
                    end
                    else if (!new_ch4 && ch4_run_reg)
                    begin
                        result.channel_event = scr_pkg::EV_STOP;
                        result.channel       = scr_pkg::CH4_NUM;
                    end
                    ch4_run_next = new_ch4;
                end

                // loop flag bytes of channels 0 to 3
                if ((offset >= scr_pkg::OFS_LOOP_LO) && (offset <= scr_pkg::OFS_LOOP_HI))
                begin
                    loop_zero_next[sub] = (item.data == '0);
                end

                // channels 0 to 3 follow bit 0 edges
                if ((offset >= scr_pkg::OFS_CH_LO) && (offset <= scr_pkg::OFS_CH_HI))
                begin
                    if (new_bit && !old_bit)
                    begin
                        result.channel_event = scr_pkg::EV_START;
                        result.channel       = {1'b0, sub};
                        result.channel_loop  = loop_zero_reg[sub];
                    end
                    else if (!new_bit && old_bit)
                    begin
                        result.channel_event = scr_pkg::EV_STOP;
                        result.channel       = {1'b0, sub};
                    end
                    ch_bit_next[sub] = new_bit;
                end

                if (offset == scr_pkg::OFS_STEP)
                begin
                    step_next = prod5[31:8];
                end

                if (offset == scr_pkg::OFS_VOL)
                begin
                    volume_next = item.data;
                end
            end
        end
        else if (item.address == scr_pkg::BANK_ADDR)
        begin
            bank_next = item.data[scr_pkg::BANK_W-1:0];
        end
        else if (item.address == scr_pkg::WDOG_ADDR)
        begin
            result.watchdog_kick = 1'b1;
        end

        result.flip         = flip_next;
        result.palette_bank = bank_next;
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_unit_reg <= scr_pkg::TONE_UNIT_RST;
        end
        else if (cfg_we)
        begin
            tone_unit_reg <= cfg_data;
        end
    end

    // device state, updated as each word moves to the output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            step_reg      <= '0;
            volume_reg    <= '0;
            flip_reg      <= '0;
            bank_reg      <= '0;
            ch4_run_reg   <= 1'b0;
            ch_bit_reg    <= '0;
            loop_zero_reg <= '1;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            volume_reg    <= volume_next;
            flip_reg      <= flip_next;
            bank_reg      <= bank_next;
            ch4_run_reg   <= ch4_run_next;
            ch_bit_reg    <= ch_bit_next;
            loop_zero_reg <= loop_zero_next;
        end
    end

endmodule

// ===== rtl/scr_out_stage.sv =====
// Output register of the sound control register device.
// Depends on scr_pkg for the result word type.

module scr_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             advance,
    input  scr_pkg::result_t result,
    output logic             out_valid,
    input  logic             out_stall,
    output scr_pkg::result_t out_word
);

    logic             valid_reg;
    logic             valid_next;
    scr_pkg::result_t word_reg;
    logic             can_load;

    // a new result may enter when the register is empty or being taken
    assign can_load = !valid_reg || !out_stall;
    assign advance  = item_valid && can_load;

    always_comb
    begin
        if (advance)
        begin
            valid_next = 1'b1;
        end
        else if (can_load)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    // control flop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload flop
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            word_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ===== rtl/sound_control_register_device.sv =====
// Sound control register device: bus write decoder and square-wave tone.
// Top level; depends on scr_pkg, scr_in_stage, scr_core, scr_out_stage.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one word per item: func
//   selects a bus write (address, data) or one audio sample tick.
//   Output channel (out_valid / out_stall) returns exactly one result word
//   per input word, in order: tone sample, flip byte, palette bank,
//   watchdog kick and any sample channel start or stop.
//   Config channel (cfg_valid / cfg_ready, tone_unit) sets the tone unit;
//   it is always ready and is meant to be written while the block is idle.
// Timing:
//   A word taken is held in the input register and moves into the output
//   register once that register can load; its result is then on the outputs.
//   One word is taken every cycle while out_stall is low; the single pass
//   through the step multiplier and phase adder between the registers sets it.
// Reset:
//   rst_n clears both registers' valid flags and all sound state; the tone
//   unit returns to its default.
// Stall:
//   While out_stall holds, the result stays on the outputs; in_stall rises
//   as soon as the input register holds a word, so at most one more word
//   is taken.

module sound_control_register_device
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           func,
    input  logic [scr_pkg::ADDR_W-1:0]     address,
    input  logic [scr_pkg::DATA_W-1:0]     data,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [scr_pkg::PHASE_W-1:0]    tone_unit,

    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [scr_pkg::SMP_W-1:0]      sample_out,
    output logic [scr_pkg::DATA_W-1:0]     flip,
    output logic [scr_pkg::BANK_W-1:0]     palette_bank,
    output logic                           watchdog_kick,
    output logic [1:0]                     channel_event,
    output logic [scr_pkg::CH_W-1:0]       channel,
    output logic                           channel_loop
);

    scr_pkg::item_t   in_item;
    scr_pkg::item_t   item;
    scr_pkg::result_t result;
    scr_pkg::result_t out_word;
    logic             item_valid;
    logic             advance;

    assign in_item.func    = func;
    assign in_item.address = address;
    assign in_item.data    = data;

    assign cfg_ready = 1'b1;

    // input register
    scr_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // decode, state and tone
    scr_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (tone_unit),
        .advance  (advance),
        .item     (item),
        .result   (result)
    );

    // output register
    scr_out_stage u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .advance    (advance),
        .result     (result),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word)
    );

    assign sample_out    = out_word.sample_out;
    assign flip          = out_word.flip;
    assign palette_bank  = out_word.palette_bank;
    assign watchdog_kick = out_word.watchdog_kick;
    assign channel_event = out_word.channel_event;
    assign channel       = out_word.channel;
    assign channel_loop  = out_word.channel_loop;

endmodule

// ===== rtl/scr_checker.sv =====
// Port-level checks of the sound control register device.
// Depends on scr_pkg; bound to sound_control_register_device below.

module scr_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [scr_pkg::SMP_W-1:0]      sample_out,
    input logic                           watchdog_kick,
    input logic [1:0]                     channel_event,
    input logic [scr_pkg::CH_W-1:0]       channel,
    input logic                           channel_loop
);

    // no event means no channel and no loop flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (channel_event == scr_pkg::EV_NONE))
            |-> (channel == '0) && !channel_loop)
        else $error("idle result carries a channel");

    // only start and stop are ever reported
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((channel_event == scr_pkg::EV_NONE)
                    || (channel_event == scr_pkg::EV_START)
                    || (channel_event == scr_pkg::EV_STOP)))
        else $error("bad channel event code");

    // a stop never loops, and names a channel up to four
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (channel_event == scr_pkg::EV_STOP))
            |-> !channel_loop && (channel <= scr_pkg::CH4_NUM))
        else $error("bad stop event");

    // results with a watchdog kick or a channel event carry no tone sample
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (watchdog_kick || (channel_event != scr_pkg::EV_NONE)))
            |-> (sample_out == '0))
        else $error("sample on a write result");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(sample_out)
            && $stable(channel_event) && $stable(channel))
        else $error("stalled result changed");

endmodule

bind sound_control_register_device scr_checker u_scr_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sample_out    (sample_out),
    .watchdog_kick (watchdog_kick),
    .channel_event (channel_event),
    .channel       (channel),
    .channel_loop  (channel_loop)
);

// ===== test/tb.sv =====
// Testbench of sound_control_register_device: bus write decoding, sample channel
// events and the square-wave tone, checked word by word against a local model.
// Depends on scr_pkg and the block's RTL only.

package tb_sound_pkg;

    import scr_pkg::*;

    // model of the block and store of the result words still due
    class sound_scoreboard;

        logic [PHASE_W-1:0] unit_step;
        logic [DATA_W-1:0]  sound_regs [SOUND_REG_COUNT];
        logic [PHASE_W-1:0] tone_phase;
        logic [PHASE_W-1:0] phase_inc;
        logic               tone_active;
        logic [DATA_W-1:0]  tone_volume;
        logic [DATA_W-1:0]  flip_byte;
        logic [BANK_W-1:0]  bank_byte;
        result_t            due_words [$];
        int                 errors;

        function new();
            unit_step   = TONE_UNIT_RST;
            foreach (sound_regs[i])
                sound_regs[i] = '0;
            tone_phase  = '0;
            phase_inc   = '0;
            tone_active = 1'b0;
            tone_volume = '0;
            flip_byte   = '0;
            bank_byte   = '0;
            errors      = 0;
        endfunction

        // work out the result word of one accepted input word
        function void note_word(logic f, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
            result_t     r;
            int          off;
            logic [7:0]  old;
            logic [63:0] prod;
            r = '0;
            r.channel_event = EV_NONE;
            if (f == FUNC_TICK)
            begin
                if (tone_active && phase_inc != '0)
                begin
                    if (tone_phase[PHASE_W-1])
                        r.sample_out = {tone_volume, 6'b0};
                    tone_phase = tone_phase + phase_inc;
                end
            end
            else if ((a & CTRL_MASK) == CTRL_BASE)
            begin
                if (a[6:4] == FLIP_SEL)
                    flip_byte = d;
            end
            else if (a >= SND_FIRST && a <= SND_LAST)
            begin
                off = int'(a - SND_FIRST);
                if (off < SOUND_REG_COUNT)
                begin
                    old = sound_regs[off];
                    if (off == OFS_CH4)
                    begin
                        if (d == CH4_RUN_CODE && old != CH4_RUN_CODE)
                        begin
                            r.channel_event = EV_START;
                            r.channel       = CH4_NUM;
                            r.channel_loop  = 1'b1;
                        end
                        else if (d != CH4_RUN_CODE && old == CH4_RUN_CODE)
                        begin
                            r.channel_event = EV_STOP;
                            r.channel       = CH4_NUM;
                        end
                    end
                    else if (off >= OFS_CH_LO && off <= OFS_CH_HI)
                    begin
                        if (d[0] && !old[0])
                        begin
                            r.channel_event = EV_START;
                            r.channel       = CH_W'(off - OFS_CH_LO);
                            r.channel_loop  = (sound_regs[off - 4] == '0);
                        end
                        else if (!d[0] && old[0])
                        begin
                            r.channel_event = EV_STOP;
                            r.channel       = CH_W'(off - OFS_CH_LO);
                        end
                    end
                    else if (off == OFS_STEP)
                    begin
                        prod        = 64'(unit_step) * 64'(d) * 64'd5;
                        phase_inc   = prod[31:8];
                        tone_active = (phase_inc != '0);
                    end
                    else if (off == OFS_VOL)
                    begin
                        tone_volume = d;
                    end
                    sound_regs[off] = d;
                end
            end
            else if (a == BANK_ADDR)
            begin
                bank_byte = d[BANK_W-1:0];
            end
            else if (a == WDOG_ADDR)
            begin
                r.watchdog_kick = 1'b1;
            end
            r.flip         = flip_byte;
            r.palette_bank = bank_byte;
            due_words.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        // compare one result word with the oldest one due
        function void check_word(result_t got);
            result_t want;
            if (due_words.size() == 0)
            begin
                $display("%0t: result word with none due, actual %h", $time, got);
                errors++;
                return;
            end
            want = due_words.pop_front();
            compare_field("sample_out", want.sample_out, got.sample_out);
            compare_field("flip", want.flip, got.flip);
            compare_field("palette_bank", want.palette_bank, got.palette_bank);
            compare_field("watchdog_kick", want.watchdog_kick, got.watchdog_kick);
            compare_field("channel_event", want.channel_event, got.channel_event);
            compare_field("channel", want.channel, got.channel);
            compare_field("channel_loop", want.channel_loop, got.channel_loop);
        endfunction

    endclass

endpackage

module tb;

    import scr_pkg::*;
    import tb_sound_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int PHASES      = 6;
    localparam int PHASE_WORDS = 305;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                in_valid      = 1'b0;
    logic                in_stall;
    logic                func          = 1'b0;
    logic [ADDR_W-1:0]   address       = '0;
    logic [DATA_W-1:0]   data          = '0;
    logic                cfg_valid     = 1'b0;
    logic                cfg_ready;
    logic [PHASE_W-1:0]  tone_unit     = TONE_UNIT_RST;
    logic                out_valid;
    logic                out_stall     = 1'b0;
    logic [SMP_W-1:0]    sample_out;
    logic [DATA_W-1:0]   flip;
    logic [BANK_W-1:0]   palette_bank;
    logic                watchdog_kick;
    logic [1:0]          channel_event;
    logic [CH_W-1:0]     channel;
    logic                channel_loop;

    sound_scoreboard     scb;
    result_t             got_word;
    bit                  calm          = 1'b0;
    int                  quiet_cycles  = 0;

    sound_control_register_device u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .address       (address),
        .data          (data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .tone_unit     (tone_unit),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample_out    (sample_out),
        .flip          (flip),
        .palette_bank  (palette_bank),
        .watchdog_kick (watchdog_kick),
        .channel_event (channel_event),
        .channel       (channel),
        .channel_loop  (channel_loop)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // monitor: note taken words, check result words, random stall, watchdog
    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
            scb.note_word(func, address, data);
        if (out_valid && !out_stall)
        begin
            got_word = '{sample_out:    sample_out,
                         flip:          flip,
                         palette_bank:  palette_bank,
                         watchdog_kick: watchdog_kick,
                         channel_event: chan_ev_t'(channel_event),
                         channel:       channel,
                         channel_loop:  channel_loop};
            scb.check_word(got_word);
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        out_stall <= !calm && ($urandom_range(99) < 12);
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // send one word, with random idle cycles ahead of it
    task automatic push_word(logic f, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
        while (!calm && $urandom_range(99) < 12)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        address  <= a;
        data     <= d;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // stop sending and wait until every result word has come back
    task automatic settle();
        in_valid <= 1'b0;
        // let the monitor note the last word taken
        @(posedge clk);
        while (scb.due_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_tone_unit(logic [PHASE_W-1:0] v);
        cfg_valid <= 1'b1;
        tone_unit <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid     <= 1'b0;
        scb.unit_step  = v;
    endtask

    // random word, weighted toward the sound registers and ticks
    task automatic random_word();
        int                pick;
        int                off;
        logic [ADDR_W-1:0] a;
        logic [DATA_W-1:0] d;
        pick = $urandom_range(99);
        a    = ADDR_W'($urandom_range(16'hffff));
        d    = DATA_W'($urandom_range(8'hff));
        if (pick < 38)
        begin
            push_word(FUNC_TICK, a, d);
        end
        else if (pick < 78)
        begin
            case ($urandom_range(9))
                0, 1:
                begin
                    off = OFS_CH4;
                    if ($urandom_range(1))
                        d = CH4_RUN_CODE;
                end
                2, 3, 4: off = OFS_CH_LO + $urandom_range(3);
                5:
                begin
                    off = OFS_LOOP_LO + $urandom_range(3);
                    if ($urandom_range(1))
                        d = '0;
                end
                6:
                begin
                    off = OFS_STEP;
                    if ($urandom_range(1))
                        d = d | 8'hc0;
                end
                7: off = OFS_VOL;
                8: off = $urandom_range(SOUND_REG_COUNT - 1);
                // offsets past the stored registers
                default: off = $urandom_range(SND_LAST - SND_FIRST, SOUND_REG_COUNT);
            endcase
            push_word(FUNC_WRITE, SND_FIRST + ADDR_W'(off), d);
        end
        else if (pick < 84)
        begin
            push_word(FUNC_WRITE, CTRL_BASE | ADDR_W'(a[6:0]), d);
        end
        else if (pick < 89)
        begin
            push_word(FUNC_WRITE, BANK_ADDR, d);
        end
        else if (pick < 93)
        begin
            push_word(FUNC_WRITE, WDOG_ADDR, d);
        end
        else
        begin
            push_word(FUNC_WRITE, a, d);
        end
    endtask

    // stimulus
    initial
    begin
        logic [PHASE_W-1:0] unit_value;
        scb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words: control window, bank, watchdog, channel events, tone
        push_word(FUNC_TICK,  16'h0000, 8'h00);
        push_word(FUNC_WRITE, 16'h9070, 8'ha5);
        push_word(FUNC_WRITE, CTRL_BASE, 8'hff);
        push_word(FUNC_WRITE, 16'h907f, 8'hff);
        push_word(FUNC_WRITE, BANK_ADDR, 8'hff);
        push_word(FUNC_WRITE, BANK_ADDR, 8'h40);
        push_word(FUNC_WRITE, WDOG_ADDR, 8'h00);
        push_word(FUNC_WRITE, SND_FIRST + 16'h04, CH4_RUN_CODE);
        push_word(FUNC_WRITE, SND_FIRST + 16'h04, CH4_RUN_CODE);
        push_word(FUNC_WRITE, SND_FIRST + 16'h04, 8'h00);
        push_word(FUNC_WRITE, SND_FIRST + 16'h0c, 8'h01);
        push_word(FUNC_WRITE, SND_FIRST + 16'h09, 8'h05);
        push_word(FUNC_WRITE, SND_FIRST + 16'h0d, 8'hff);
        push_word(FUNC_WRITE, SND_FIRST + 16'h0c, 8'h00);
        push_word(FUNC_WRITE, SND_FIRST + 16'h0f, 8'h01);
        push_word(FUNC_WRITE, SND_FIRST + 16'h10, 8'hff);
        push_word(FUNC_WRITE, SND_FIRST + 16'h11, 8'hff);
        push_word(FUNC_TICK,  16'hffff, 8'hff);
        push_word(FUNC_WRITE, SND_FIRST + 16'h23, 8'h77);
        push_word(FUNC_WRITE, SND_FIRST + 16'h24, 8'h01);
        push_word(FUNC_WRITE, SND_LAST, 8'hff);
        push_word(FUNC_WRITE, 16'hffff, 8'hff);
        push_word(FUNC_WRITE, SND_FIRST + 16'h10, 8'h00);
        push_word(FUNC_TICK,  16'hffff, 8'hff);

        // random phases, each under its own tone unit
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph != 0)
            begin
                settle();
                case (ph)
                    1: unit_value = 24'hffffff;
                    2: unit_value = 24'd0;
                    4: unit_value = 24'd1;
                    default: unit_value = PHASE_W'($urandom_range(24'hffffff));
                endcase
                load_tone_unit(unit_value);
            end
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                calm = (ph == 2 && n < 160);
                if (ph == 3 && n == 120)
                    settle();
                random_word();
            end
        end

        settle();
        if (scb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sound_control_register_device.f =====
rtl/scr_pkg.sv
rtl/scr_in_stage.sv
rtl/scr_core.sv
rtl/scr_out_stage.sv
rtl/sound_control_register_device.sv
rtl/scr_checker.sv
test/tb.sv
